[hdl/dfr_pkg.sv]
// dfr_pkg: shared types and constants for the delimited frame receiver.
// No dependencies; imported by dfr_ctrl and delimited_frame_receiver_top.
`timescale 1ns / 1ps

package dfr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned OUT_TDATA_W = 16;
    localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - BYTE_W - IDX_W;

    // frame delimiters and type codes
    localparam logic [BYTE_W-1:0] FRAME_MARKER = 8'h7E;
    localparam logic [BYTE_W-1:0] TYPE_CODE_B  = 8'h42;
    localparam logic [BYTE_W-1:0] TYPE_CODE_E  = 8'h45;
    localparam logic [BYTE_W-1:0] TYPE_CODE_H  = 8'h48;
    localparam logic [BYTE_W-1:0] TYPE_CODE_P  = 8'h50;

    // byte offsets of the header fields within a frame
    localparam int unsigned OFF_START  = 0;
    localparam int unsigned OFF_TYPE   = 1;
    localparam int unsigned OFF_LEN_LO = 2;
    localparam int unsigned OFF_LEN_HI = 3;

    // header + sum + end marker
    localparam int unsigned FRAME_OVERHEAD = 6;

    typedef struct packed {
        logic we;
        logic re;
    } mem_cmd_t;

    function automatic logic is_frame_type(input logic [BYTE_W-1:0] b);
        return (b == TYPE_CODE_B) || (b == TYPE_CODE_E) ||
               (b == TYPE_CODE_H) || (b == TYPE_CODE_P);
    endfunction

endpackage

[hdl/dfr_store.sv]
// dfr_store: single-port byte store, synchronous write, registered read.
// Standalone; used by dfr_ctrl through delimited_frame_receiver_top.
`timescale 1ns / 1ps

module dfr_store #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [7:0]               wdata,
    output logic [7:0]               rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

[hdl/dfr_ctrl.sv]
// dfr_ctrl: sequencer that appends, resyncs, checks and emits frames held in
// the byte store (circular, head pointer + fill count). Uses dfr_pkg.
`timescale 1ns / 1ps

module dfr_ctrl #(
    parameter int unsigned MAX_PAYLOAD = 40,
    parameter int unsigned STORE_DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // byte input
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [dfr_pkg::BYTE_W-1:0]       in_byte,
    // frame output
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [dfr_pkg::BYTE_W-1:0]       out_byte,
    output logic [dfr_pkg::IDX_W-1:0]        out_index,
    output logic                             out_last,
    // store port
    output dfr_pkg::mem_cmd_t                mem_cmd,
    output logic [$clog2(STORE_DEPTH)-1:0]   mem_addr,
    output logic [dfr_pkg::BYTE_W-1:0]       mem_wdata,
    input  logic [dfr_pkg::BYTE_W-1:0]       mem_rdata
);

    import dfr_pkg::*;

    localparam int unsigned AW = $clog2(STORE_DEPTH);
    localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
    localparam int unsigned PW = CW + 1;
    localparam int unsigned NW = LEN_W + 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RS_RD,
        ST_RS_CHK,
        ST_LEN2,
        ST_LEN3,
        ST_LEN_CHK,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_CK_RD,
        ST_CK_EVAL,
        ST_EM_RD,
        ST_EM_LD
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       need_reg, need_next;
    logic [BYTE_W-1:0]   sum_reg, sum_next;
    logic [BYTE_W-1:0]   len_lo_reg, len_lo_next;
    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic [IDX_W-1:0]    out_index_reg, out_index_next;
    logic                out_last_reg, out_last_next;

    logic [CW-1:0]       mem_off;
    logic [PW-1:0]       addr_sum;
    logic [AW-1:0]       head_inc;
    logic [CW-1:0]       fill_inc;
    logic [LEN_W-1:0]    len_full;
    logic [NW-1:0]       need_wide;
    logic [CW-1:0]       sum_last_off;
    logic [CW-1:0]       chk_off;
    logic [CW-1:0]       end_off;

    // logical offset -> physical entry, wrapping at STORE_DEPTH
    assign addr_sum = PW'(head_reg) + PW'(mem_off);
    assign mem_addr = (addr_sum >= PW'(STORE_DEPTH)) ? AW'(addr_sum - PW'(STORE_DEPTH))
                                                     : AW'(addr_sum);

    assign head_inc     = (head_reg == AW'(STORE_DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign fill_inc     = fill_reg + CW'(1);
    assign len_full     = {mem_rdata, len_lo_reg};
    assign need_wide    = NW'(len_full) + NW'(FRAME_OVERHEAD);
    assign sum_last_off = need_reg - CW'(3);
    assign chk_off      = need_reg - CW'(2);
    assign end_off      = need_reg - CW'(1);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        need_next      = need_reg;
        sum_next       = sum_reg;
        len_lo_next    = len_lo_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        out_byte_next  = out_byte_reg;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;
        mem_cmd        = '0;
        mem_off        = cnt_reg;
        mem_wdata      = in_byte;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mem_cmd.we = 1'b1;
                    if (fill_reg == CW'(STORE_DEPTH))
                    begin
                        // full: overwrite the oldest entry, head moves past it
                        mem_off    = '0;
                        head_next  = head_inc;
                        cnt_next   = '0;
                        state_next = ST_RS_RD;
                    end
                    else
                    begin
                        mem_off   = fill_reg;
                        fill_next = fill_inc;
                        cnt_next  = '0;
                        if (fill_inc == CW'(OFF_LEN_HI))
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (fill_inc <= CW'(OFF_LEN_HI + 1))
                        begin
                            state_next = ST_RS_RD;
                        end
                        else
                        begin
                            state_next = ST_LEN2;
                        end
                    end
                end
            end

            ST_RS_RD:
            begin
                if (fill_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_cmd.re = 1'b1;
                    state_next = ST_RS_CHK;
                end
            end

            ST_RS_CHK:
            begin
                logic bad;
                logic more;
                bad  = 1'b0;
                more = 1'b0;
                case (cnt_reg[1:0])
                    2'(OFF_START):
                    begin
                        bad  = (mem_rdata != FRAME_MARKER);
                        more = (fill_reg > CW'(OFF_TYPE));
                    end
                    2'(OFF_TYPE):
                    begin
                        bad  = !is_frame_type(mem_rdata);
                        more = (fill_reg > CW'(OFF_LEN_HI));
                    end
                    2'(OFF_LEN_LO):
                    begin
                        len_lo_next = mem_rdata;
                        more        = 1'b1;
                    end
                    default:
                    begin
                        bad = (len_full > LEN_W'(MAX_PAYLOAD));
                    end
                endcase
                if (bad)
                begin
                    head_next  = head_inc;
                    fill_next  = fill_reg - CW'(1);
                    cnt_next   = '0;
                    state_next = ST_RS_RD;
                end
                else if (more)
                begin
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = ST_RS_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_LEN2:
            begin
                mem_off    = CW'(OFF_LEN_LO);
                mem_cmd.re = 1'b1;
                state_next = ST_LEN3;
            end

            ST_LEN3:
            begin
                len_lo_next = mem_rdata;
                mem_off     = CW'(OFF_LEN_HI);
                mem_cmd.re  = 1'b1;
                state_next  = ST_LEN_CHK;
            end

            ST_LEN_CHK:
            begin
                if (need_wide > NW'(fill_reg))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    need_next  = CW'(need_wide);
                    cnt_next   = CW'(OFF_TYPE);
                    sum_next   = '0;
                    state_next = ST_SUM_RD;
                end
            end

            ST_SUM_RD:
            begin
                mem_cmd.re = 1'b1;
                state_next = ST_SUM_ACC;
            end

            ST_SUM_ACC:
            begin
                sum_next = sum_reg + mem_rdata;
                if (cnt_reg == sum_last_off)
                begin
                    cnt_next   = chk_off;
                    state_next = ST_CK_RD;
                end
                else
                begin
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = ST_SUM_RD;
                end
            end

            ST_CK_RD:
            begin
                mem_cmd.re = 1'b1;
                state_next = ST_CK_EVAL;
            end

            ST_CK_EVAL:
            begin
                logic good;
                good = (cnt_reg == chk_off) ? (mem_rdata == sum_reg)
                                            : (mem_rdata == FRAME_MARKER);
                if (!good)
                begin
                    head_next  = head_inc;
                    fill_next  = fill_reg - CW'(1);
                    cnt_next   = '0;
                    state_next = ST_RS_RD;
                end
                else if (cnt_reg == chk_off)
                begin
                    cnt_next   = end_off;
                    state_next = ST_CK_RD;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = ST_EM_RD;
                end
            end

            ST_EM_RD:
            begin
                mem_cmd.re = 1'b1;
                state_next = ST_EM_LD;
            end

            ST_EM_LD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = mem_rdata;
                    out_index_next = IDX_W'(cnt_reg);
                    out_last_next  = (cnt_reg == end_off);
                    if (cnt_reg == end_off)
                    begin
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + CW'(1);
                        state_next = ST_EM_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            need_reg      <= '0;
            sum_reg       <= '0;
            len_lo_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_index_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            need_reg      <= need_next;
            sum_reg       <= sum_next;
            len_lo_reg    <= len_lo_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_index_reg <= out_index_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_index = out_index_reg;
    assign out_last  = out_last_reg;

endmodule

[hdl/delimited_frame_receiver_top.sv]
// delimited_frame_receiver_top: byte stream in, validated frames out.
// Instantiates dfr_ctrl and dfr_store; uses dfr_pkg.
`timescale 1ns / 1ps
//
// Usage
//   s_axis carries one received byte per item. m_axis carries the bytes of
//   each good frame (7E, type, len lo, len hi, payload, sum, 7E), start
//   marker first; tlast marks the end marker. tdata also carries the byte's
//   position in the frame.
//   Bytes are held in a single-port store of STORE_DEPTH entries with a head
//   pointer and fill count. All checks read the store one entry at a time.
// Sequencing
//   A byte that leaves three held returns straight to idle. From five held
//   on, the length is fetched first; a frame still short waits in idle. A
//   prefix resync reads and checks one header byte at a time; a failed check
//   drops the oldest byte and restarts, so the worst case grows with fill
//   count. A complete frame of N = len+6 bytes: the length is fetched, the
//   N-3 bytes type through payload are summed, sum and end marker are
//   checked, then each byte is read and emitted in turn.
// Reset: fill count and control state clear; the store contents are not
//   cleared, entries are only read after being written.
// Stall: while m_axis is held off, emission waits on the output register and
//   s_axis_tready stays low; the last byte of a frame may wait in the output
//   register while the next input byte is taken.

module delimited_frame_receiver_top #(
    parameter int unsigned MAX_PAYLOAD = 40,
    parameter int unsigned STORE_DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input: [7:0] rx_byte
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [dfr_pkg::BYTE_W-1:0]          s_axis_tdata,
    // output: [7:0] frame_byte, [13:8] byte_index, [15:14] zero
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [dfr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast
);

    import dfr_pkg::*;

    localparam int unsigned AW = $clog2(STORE_DEPTH);

    mem_cmd_t            mem_cmd;
    logic [AW-1:0]       mem_addr;
    logic [BYTE_W-1:0]   mem_wdata;
    logic [BYTE_W-1:0]   mem_rdata;
    logic [BYTE_W-1:0]   frame_byte;
    logic [IDX_W-1:0]    byte_index;

    dfr_ctrl #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (frame_byte),
        .out_index (byte_index),
        .out_last  (m_axis_tlast),
        .mem_cmd   (mem_cmd),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    dfr_store #(
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_cmd.we),
        .re    (mem_cmd.re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, byte_index, frame_byte};

endmodule
